[src/fib_pkg.sv]
`default_nettype none
package fib_pkg;

  // Field widths fixed by the interface
  localparam int VERTEX_BITS = 20;
  localparam int EDGE_W      = 6;
  localparam int FILL_W      = 15;
  localparam int SLOT_W      = 14;

  // Legal batch limit range; register values outside are clamped
  localparam logic [FILL_W-1:0] LIMIT_MIN = 15'd96;
  localparam logic [FILL_W-1:0] LIMIT_MAX = 15'd16384;

  // Result kinds
  localparam logic KIND_TRI   = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic [VERTEX_BITS-1:0] first_vertex;
    logic [EDGE_W-1:0]      num_edges;
    logic                   chain_end;
  } in_item_t;

  typedef struct packed {
    logic                   kind;
    logic [SLOT_W-1:0]      slot;
    logic [VERTEX_BITS-1:0] corner_a;
    logic [VERTEX_BITS-1:0] corner_b;
    logic [VERTEX_BITS-1:0] corner_c;
    logic [FILL_W-1:0]      flush_count;
    logic                   last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRE,
    ST_TRI,
    ST_POST
  } fib_state_t;

  // Sequencer commands to the fan unit
  typedef struct packed {
    logic load;
    logic step;
    logic clr;
  } fib_ctl_t;

  // Fan unit status to the sequencer
  typedef struct packed {
    logic acc_pre;
    logic acc_tris;
    logic cnt_zero;
    logic cnt_one;
    logic fill_zero;
  } fib_stat_t;

endpackage
`default_nettype wire

[src/fib_fan_unit.sv]
`default_nettype none
module fib_fan_unit #(
  parameter int MAX_EDGES = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire fib_pkg::in_item_t                  in_data,
  input  wire logic [fib_pkg::FILL_W-1:0]         limit,
  input  wire fib_pkg::fib_ctl_t                  ctl,
  output fib_pkg::fib_stat_t                      stat,
  output logic [fib_pkg::FILL_W-1:0]              fill,
  output logic [fib_pkg::VERTEX_BITS-1:0]         vtx_a,
  output logic [fib_pkg::VERTEX_BITS-1:0]         vtx_b,
  output logic [fib_pkg::VERTEX_BITS-1:0]         vtx_c
);
  import fib_pkg::*;

  localparam int TRI_W  = $clog2(MAX_EDGES);
  localparam int NEED_W = TRI_W + 2;

  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic [TRI_W-1:0]       cnt_r, cnt_nxt;
  logic [VERTEX_BITS-1:0] first_r, first_nxt;
  logic [VERTEX_BITS-1:0] vtx_r, vtx_nxt;

  logic [EDGE_W-1:0]      edges_c;
  logic [TRI_W-1:0]       tris_c;
  logic [NEED_W-1:0]      need_c;
  logic [FILL_W-1:0]      lim_c;
  logic [FILL_W:0]        sum_c;
  logic [VERTEX_BITS-1:0] vtx_inc;

  // Size the incoming polygon and test it against the batch limit
  always_comb begin
    edges_c = (in_data.num_edges > EDGE_W'(MAX_EDGES)) ? EDGE_W'(MAX_EDGES)
                                                        : in_data.num_edges;
    tris_c  = (edges_c >= EDGE_W'(3)) ? TRI_W'(edges_c - EDGE_W'(2)) : '0;
    need_c  = NEED_W'({tris_c, 1'b0}) + NEED_W'(tris_c);
    if (limit < LIMIT_MIN) begin
      lim_c = LIMIT_MIN;
    end else if (limit > LIMIT_MAX) begin
      lim_c = LIMIT_MAX;
    end else begin
      lim_c = limit;
    end
    sum_c = {1'b0, fill_r} + (FILL_W+1)'(need_c);
  end

  // Shared vertex incrementer: third corner now, second corner next step
  assign vtx_inc = vtx_r + VERTEX_BITS'(1);

  always_comb begin
    stat.acc_pre   = (sum_c >= {1'b0, lim_c}) && (fill_r != '0);
    stat.acc_tris  = (tris_c != '0);
    stat.cnt_zero  = (cnt_r == '0);
    stat.cnt_one   = (cnt_r == TRI_W'(1));
    stat.fill_zero = (fill_r == '0);
  end

  // Load on a new polygon, advance one triangle per step, drop the fill on flush
  always_comb begin
    fill_nxt  = fill_r;
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    vtx_nxt   = vtx_r;
    if (ctl.load) begin
      first_nxt = in_data.first_vertex;
      vtx_nxt   = in_data.first_vertex + VERTEX_BITS'(1);
      cnt_nxt   = tris_c;
    end
    if (ctl.step) begin
      fill_nxt = fill_r + FILL_W'(3);
      vtx_nxt  = vtx_inc;
      cnt_nxt  = cnt_r - TRI_W'(1);
    end
    if (ctl.clr) begin
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      cnt_r  <= '0;
    end else begin
      fill_r <= fill_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    vtx_r   <= vtx_nxt;
  end

  assign fill  = fill_r;
  assign vtx_a = first_r;
  assign vtx_b = vtx_r;
  assign vtx_c = vtx_inc;

endmodule
`default_nettype wire

[src/fib_seq.sv]
`default_nettype none
module fib_seq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_chain_end,
  input  wire logic               adv,
  input  wire fib_pkg::fib_stat_t stat,
  output fib_pkg::fib_ctl_t       ctl,
  output logic                    busy,
  output logic                    emit,
  output logic                    emit_kind,
  output logic                    emit_last
);
  import fib_pkg::*;

  fib_state_t state_r, state_nxt;
  logic       chain_r, chain_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      chain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chain_r <= chain_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    chain_nxt = chain_r;
    ctl       = '0;
    emit      = 1'b0;
    emit_kind = KIND_TRI;
    emit_last = 1'b0;
    busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          chain_nxt = in_chain_end;
          if (stat.acc_pre) begin
            state_nxt = ST_PRE;
          end else if (stat.acc_tris) begin
            state_nxt = ST_TRI;
          end else if (in_chain_end && !stat.fill_zero) begin
            state_nxt = ST_POST;
          end
        end
      end
      ST_PRE: begin
        if (adv) begin
          emit      = 1'b1;
          emit_kind = KIND_FLUSH;
          ctl.clr   = 1'b1;
          emit_last = stat.cnt_zero;
          state_nxt = stat.cnt_zero ? ST_IDLE : ST_TRI;
        end
      end
      ST_TRI: begin
        if (adv) begin
          emit      = 1'b1;
          emit_kind = KIND_TRI;
          ctl.step  = 1'b1;
          emit_last = stat.cnt_one && !chain_r;
          if (stat.cnt_one) begin
            state_nxt = chain_r ? ST_POST : ST_IDLE;
          end
        end
      end
      ST_POST: begin
        if (adv) begin
          emit      = 1'b1;
          emit_kind = KIND_FLUSH;
          ctl.clr   = 1'b1;
          emit_last = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/fan_index_batcher_core.sv]
`default_nettype none
// Channel    Direction  Handshake             Payload
// in_        input      in_valid / in_stall   fib_pkg::in_item_t (one polygon)
// out_       output     out_valid / out_stall fib_pkg::out_item_t (triangle or flush)
// cfg_       input      cfg_we                cfg_data (batch limit)
//
// A polygon is taken while the core is idle; then, while the output is not
// stalled, its results leave one per cycle: an optional flush, one triangle
// per cycle from the shared vertex incrementer, an optional chain-end flush.
// The next polygon is taken once the last result sits in the output
// register. Reset (rst_n low, synchronous) empties the batch and sets the
// limit to 16384. Output stall freezes the sequencer.
module fan_index_batcher_core #(
  parameter int MAX_EDGES = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire fib_pkg::in_item_t            in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output fib_pkg::out_item_t                out_data,
  input  wire logic                         cfg_we,
  input  wire logic [fib_pkg::FILL_W-1:0]   cfg_data
);
  import fib_pkg::*;

  logic [FILL_W-1:0]      limit_r;
  logic                   out_valid_r;
  out_item_t              out_data_r, out_data_nxt;
  logic                   adv, busy, emit, emit_kind, emit_last;
  fib_ctl_t               ctl;
  fib_stat_t              stat;
  logic [FILL_W-1:0]      fill;
  logic [VERTEX_BITS-1:0] vtx_a, vtx_b, vtx_c;

  // Batch limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_MAX;
    end else if (cfg_we) begin
      limit_r <= cfg_data;
    end
  end

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = busy;

  fib_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_chain_end (in_data.chain_end),
    .adv          (adv),
    .stat         (stat),
    .ctl          (ctl),
    .busy         (busy),
    .emit         (emit),
    .emit_kind    (emit_kind),
    .emit_last    (emit_last)
  );

  fib_fan_unit #(
    .MAX_EDGES (MAX_EDGES)
  ) u_fan (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .limit   (limit_r),
    .ctl     (ctl),
    .stat    (stat),
    .fill    (fill),
    .vtx_a   (vtx_a),
    .vtx_b   (vtx_b),
    .vtx_c   (vtx_c)
  );

  // Build the next result transaction; unused fields stay zero
  always_comb begin
    out_data_nxt      = '0;
    out_data_nxt.kind = emit_kind;
    out_data_nxt.last = emit_last;
    if (emit_kind == KIND_FLUSH) begin
      out_data_nxt.flush_count = fill;
    end else begin
      out_data_nxt.slot     = fill[SLOT_W-1:0];
      out_data_nxt.corner_a = vtx_a;
      out_data_nxt.corner_b = vtx_b;
      out_data_nxt.corner_c = vtx_c;
    end
  end

  // Output register: load on emit, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[src/fib_checker.sv]
`default_nettype none
module fib_assertions (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire fib_pkg::out_item_t out_data
);
  import fib_pkg::*;

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A flush carries a non-empty batch and no triangle fields
  a_flush_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_FLUSH) |->
      (out_data.flush_count != '0) && (out_data.slot == '0) &&
      (out_data.corner_a == '0) && (out_data.corner_b == '0) &&
      (out_data.corner_c == '0))
    else $error("malformed flush");

  // Triangle corners b and c are consecutive fan vertices, and a triangle carries no flush count
  a_tri_corners: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_TRI) |->
      (out_data.corner_c == out_data.corner_b + VERTEX_BITS'(1)) &&
      (out_data.flush_count == '0))
    else $error("malformed triangle");

  // Consecutive triangles of one polygon advance by one vertex and three slots
  a_tri_advance: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_data.kind == KIND_TRI) && !out_data.last
      ##1 out_valid && (out_data.kind == KIND_TRI) |->
      (out_data.corner_b == $past(out_data.corner_c)) &&
      (out_data.slot == $past(out_data.slot) + SLOT_W'(3)))
    else $error("triangle sequence broken");

endmodule

bind fan_index_batcher_core fib_assertions u_fib_assertions (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

[tb/fib_checker.sv]
`timescale 1ns / 1ps
module fib_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  fib_pkg::in_item_t          in_data,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  fib_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [fib_pkg::FILL_W-1:0] cfg_data,
  output int                         errors,
  output int                         pending,
  output int                         results_checked
);
  import fib_pkg::*;

  localparam int MAX_EDGES = 32;

  logic [FILL_W-1:0] limit_reg;
  logic [FILL_W-1:0] batch_fill;
  out_item_t         expected_results[$];

  function automatic out_item_t flush_result(input logic [FILL_W-1:0] count);
    out_item_t r;
    r             = '0;
    r.kind        = KIND_FLUSH;
    r.flush_count = count;
    return r;
  endfunction

  // Expand one polygon into its fan triangles and flushes, update the batch fill
  task automatic expand_polygon(input in_item_t poly);
    int        lim;
    int        edges;
    int        tris;
    int        need;
    out_item_t r;
    out_item_t batch[$];
    lim = int'(limit_reg);
    if (lim < int'(LIMIT_MIN)) lim = int'(LIMIT_MIN);
    if (lim > int'(LIMIT_MAX)) lim = int'(LIMIT_MAX);
    edges = int'(poly.num_edges);
    if (edges > MAX_EDGES) edges = MAX_EDGES;
    tris = (edges >= 3) ? edges - 2 : 0;
    need = 3 * tris;

    // Flush first when this polygon would reach the limit
    if (int'(batch_fill) + need >= lim) begin
      if (batch_fill != '0) batch.push_back(flush_result(batch_fill));
      batch_fill = '0;
    end

    for (int v = 0; v < tris; v++) begin
      r          = '0;
      r.kind     = KIND_TRI;
      r.slot     = SLOT_W'(int'(batch_fill) + 3 * v);
      r.corner_a = poly.first_vertex;
      r.corner_b = poly.first_vertex + VERTEX_BITS'(v + 1);
      r.corner_c = poly.first_vertex + VERTEX_BITS'(v + 2);
      batch.push_back(r);
    end
    batch_fill = batch_fill + FILL_W'(need);

    // Close the chain with its own flush
    if (poly.chain_end && batch_fill != '0) begin
      batch.push_back(flush_result(batch_fill));
      batch_fill = '0;
    end

    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_results.push_back(batch[i]);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Sample both channels and the config port at each rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      limit_reg       = LIMIT_MAX;
      batch_fill      = '0;
      errors          = 0;
      results_checked = 0;
      expected_results.delete();
    end else begin
      if (in_valid && !in_stall) expand_polygon(in_data);

      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          $error("result transaction with no expected result (kind %0d)", out_data.kind);
          errors++;
        end else begin
          out_item_t exp_r;
          exp_r = expected_results.pop_front();
          check_field("kind",        32'(exp_r.kind),        32'(out_data.kind));
          check_field("slot",        32'(exp_r.slot),        32'(out_data.slot));
          check_field("corner_a",    32'(exp_r.corner_a),    32'(out_data.corner_a));
          check_field("corner_b",    32'(exp_r.corner_b),    32'(out_data.corner_b));
          check_field("corner_c",    32'(exp_r.corner_c),    32'(out_data.corner_c));
          check_field("flush_count", 32'(exp_r.flush_count), 32'(out_data.flush_count));
          check_field("last",        32'(exp_r.last),        32'(out_data.last));
        end
      end

      if (cfg_we) limit_reg = cfg_data;
    end
    pending = expected_results.size();
  end

endmodule

[tb/tb_fan_index_batcher_core.sv]
`timescale 1ns / 1ps
module tb_fan_index_batcher_core;
  import fib_pkg::*;

  localparam int SETTLE_CYCLES = 100;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  in_item_t          in_data   = '0;
  logic              out_stall = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [FILL_W-1:0] cfg_data  = '0;
  logic              in_stall;
  logic              out_valid;
  out_item_t         out_data;

  int          errors;
  int          pending;
  int          results_checked;
  int          polys_sent   = 0;
  int          limit_writes = 0;
  int unsigned stall_hold   = 0;
  int unsigned stall_pick;
  int          burst_left   = 0;

  always #2 clk = ~clk;

  fan_index_batcher_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  fib_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .errors          (errors),
    .pending         (pending),
    .results_checked (results_checked)
  );

  // Hold the result stall in runs: mostly short, a few long, some quiet stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 55) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(0, 7);
      end else if (stall_pick < 85) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(0, 2);
      end else if (stall_pick < 97) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(20, 80);
      end else begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(10, 40);
      end
    end
  end

  function automatic int pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) burst_left = $urandom_range(10, 30);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one polygon and hold it until the core takes it
  task automatic send_poly(input logic [VERTEX_BITS-1:0] first_v, input int edges,
                           input logic chain_end);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid               <= 1'b1;
    in_data.first_vertex   <= first_v;
    in_data.num_edges      <= EDGE_W'(edges);
    in_data.chain_end      <= chain_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    polys_sent++;
  endtask

  // Draw a random polygon: mostly real fans, some degenerate or oversized
  task automatic send_random_poly(input int chain_pct, input bit big);
    int unsigned           r;
    int                    edges;
    logic [VERTEX_BITS-1:0] first_v;
    r = $urandom_range(0, 99);
    if (big)          edges = $urandom_range(28, 32);
    else if (r < 8)   edges = $urandom_range(0, 2);
    else if (r < 12)  edges = $urandom_range(33, 63);
    else if (r < 30)  edges = 32;
    else              edges = $urandom_range(3, 32);
    if ($urandom_range(0, 99) < 15) first_v = VERTEX_BITS'($urandom_range(20'hFFFC0, 20'hFFFFF));
    else                            first_v = VERTEX_BITS'($urandom);
    send_poly(first_v, edges, $urandom_range(0, 99) < chain_pct);
  endtask

  task automatic run_phase(input int count, input int chain_pct, input bit big);
    for (int i = 0; i < count; i++) send_random_poly(chain_pct, big);
  endtask

  // Drop valid, drain all expected results, let the core go idle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [FILL_W-1:0] value);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    limit_writes++;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset limit: smallest fan, wrap, degenerate and clamped edge counts
    send_poly(20'h00000, 3, 1'b0);
    send_poly(20'hFFFFF, 32, 1'b0);
    send_poly(20'hFFFFE, 5, 1'b1);
    send_poly(20'h12345, 0, 1'b1);
    send_poly(20'h00001, 1, 1'b0);
    send_poly(20'h55555, 4, 1'b0);
    send_poly(20'hAAAAA, 2, 1'b1);
    send_poly(20'h0F0F0, 33, 1'b0);
    send_poly(20'hF0F0F, 63, 1'b1);
    send_poly(20'h7FFFF, 31, 1'b0);
    send_poly(20'h80000, 3, 1'b1);

    // Limit below range acts as the minimum; walk the fill up to it exactly
    write_limit(15'd0);
    send_poly(20'h00010, 32, 1'b0);
    send_poly(20'h00200, 3, 1'b0);
    send_poly(20'h00300, 3, 1'b0);
    send_poly(20'h00400, 32, 1'b0);
    send_poly(20'h00500, 2, 1'b0);
    send_poly(20'h00600, 4, 1'b1);
    run_phase(60, 10, 1'b0);

    write_limit(15'd97);
    run_phase(50, 20, 1'b0);

    // Above range acts as the maximum; fill the largest batch without closing it
    write_limit(15'h7FFF);
    run_phase(200, 0, 1'b1);

    // Lower the limit under the open batch's fill
    write_limit(15'd95);
    run_phase(40, 15, 1'b0);

    write_limit(15'd16385);
    run_phase(40, 5, 1'b0);

    write_limit(FILL_W'($urandom_range(96, 600)));
    run_phase(60, 10, 1'b0);

    drain();
    $display("Checked %0d results from %0d polygons under %0d batch limit settings",
             results_checked, polys_sent, limit_writes + 1);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #8_000_000;
    $error("timeout with %0d results still expected", pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule

[files.f]
src/fib_pkg.sv
src/fib_fan_unit.sv
src/fib_seq.sv
src/fan_index_batcher_core.sv
src/fib_checker.sv
tb/fib_checker.sv
tb/tb_fan_index_batcher_core.sv
